[sv/kmp_pkg.sv]
// Shared types and constants for the KMP substring search core.
// Holds the transaction structs, mode codes and cell control struct.
// No dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] MODE_PATTERN = 2'd0;
  localparam logic [1:0] MODE_TEXT    = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
    logic       text_last;
  } in_t;

  typedef struct packed {
    logic             match_end;
    logic             found;
    logic             done_res;
    logic [LEN_W-1:0] pattern_length;
    logic             overflow;
  } out_t;

  // Broadcast to every cell of the row in the cycle a transaction is accepted.
  typedef struct packed {
    logic       load;
    logic       text;
    logic       clear;
    logic       text_last;
    logic [7:0] symbol;
  } cell_ctl_t;

endpackage

[sv/kmp_substring_search_core.sv]
// Top level of the KMP substring search core: handshake, length counter,
// output register and the row of kmp_cell instances.
// Depends on kmp_pkg and kmp_cell.
//
// Usage: send pattern bytes (mode 0), then text bytes (mode 1) with
// text_last on the final byte of each text; mode 2 clears pattern and match
// state. Every transaction, whatever its mode, gives exactly one result,
// registered and shown in the cycle after acceptance, and a new transaction
// is taken every cycle while the result side keeps up: the whole row of
// MAX_PATTERN cells compares the byte and passes partial-match flags to
// its neighbors in parallel. An empty pattern matches every text byte.
// Pattern bytes beyond MAX_PATTERN are dropped and flagged with overflow.
module kmp_substring_search_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmp_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output kmp_pkg::out_t  out_item
);

  localparam int N = kmp_pkg::MAX_PATTERN;
  localparam int W = kmp_pkg::LEN_W;

  logic               accept;
  logic               full;
  kmp_pkg::cell_ctl_t ctl;
  logic [N-1:0]       active;
  logic [N-1:0]       occupied;
  logic [N-1:0]       hit;
  logic [W-1:0]       pattern_length;
  logic [W-1:0]       pattern_length_next;
  logic               any_found;
  logic               any_found_next;
  kmp_pkg::out_t      result;
  logic               is_pattern;
  logic               is_text;
  logic               is_clear;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (pattern_length == W'(N));

  assign is_pattern = accept && (in_item.mode == kmp_pkg::MODE_PATTERN);
  assign is_text    = accept && (in_item.mode == kmp_pkg::MODE_TEXT);
  assign is_clear   = accept && (in_item.mode == kmp_pkg::MODE_CLEAR);

  always_comb begin
    ctl.load      = is_pattern && !full;
    ctl.text      = is_text;
    ctl.clear     = is_clear;
    ctl.text_last = in_item.text_last;
    ctl.symbol    = in_item.symbol;
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic prev_active;
      logic prev_occupied;
      logic next_occupied;
      if (g == 0) begin : g_head
        assign prev_active   = 1'b1;
        assign prev_occupied = 1'b1;
      end else begin : g_body
        assign prev_active   = active[g-1];
        assign prev_occupied = occupied[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign next_occupied = 1'b0;
      end else begin : g_inner
        assign next_occupied = occupied[g+1];
      end
      kmp_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctl           (ctl),
        .prev_active   (prev_active),
        .prev_occupied (prev_occupied),
        .next_occupied (next_occupied),
        .active        (active[g]),
        .occupied      (occupied[g]),
        .hit           (hit[g])
      );
    end
  endgenerate

  always_comb begin
    pattern_length_next = pattern_length;
    any_found_next      = any_found;
    result              = '0;
    if (ctl.load) begin
      pattern_length_next = pattern_length + W'(1);
      any_found_next      = 1'b0;
    end
    if (is_clear) begin
      pattern_length_next = '0;
      any_found_next      = 1'b0;
    end
    if (is_text) begin
      result.match_end = (pattern_length == '0) || (|hit);
      result.found     = any_found || result.match_end;
      result.done_res  = in_item.text_last;
      any_found_next   = in_item.text_last ? 1'b0 : result.found;
    end
    result.overflow       = is_pattern && full;
    result.pattern_length = pattern_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      any_found      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pattern_length <= pattern_length_next;
      any_found      <= any_found_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  // The occupied flags form a prefix whose count must equal pattern_length.
  a_length_tracks_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == int'(pattern_length))
    else $error("occupied cell count differs from pattern length");

  a_last_clears_match: assert property (@(posedge clk) disable iff (rst)
    is_text && in_item.text_last |=> active == '0)
    else $error("match state not cleared after last text byte");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |-> out_item.pattern_length == W'(N))
    else $error("overflow reported with room left");

  a_match_sets_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.match_end |-> out_item.found)
    else $error("match reported without found");
`endif

endmodule

[sv/kmp_cell.sv]
// One cell of the matching row: one pattern byte, its occupied flag and
// the partial-match flag for the prefix that ends at this cell.
// Depends on kmp_pkg.
module kmp_cell (
  input  logic              clk,
  input  logic              rst,
  input  kmp_pkg::cell_ctl_t ctl,
  input  logic              prev_active,
  input  logic              prev_occupied,
  input  logic              next_occupied,
  output logic              active,
  output logic              occupied,
  output logic              hit
);

  logic [7:0] pattern_byte;
  logic       candidate;
  logic       take_byte;

  // The prefix ending here extends if the shorter one ended at the previous byte.
  assign candidate = prev_active && occupied && (ctl.symbol == pattern_byte);
  assign hit       = candidate && !next_occupied;
  assign take_byte = ctl.load && prev_occupied && !occupied;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      occupied <= 1'b0;
    end else if (take_byte) begin
      occupied <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      pattern_byte <= ctl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear || ctl.load) begin
      active <= 1'b0;
    end else if (ctl.text) begin
      active <= ctl.text_last ? 1'b0 : candidate;
    end
  end

endmodule

[tb/kmp_substring_search_core_tb.sv]
// Testbench for kmp_substring_search_core: streams pattern, text, clear and
// no-op transactions, predicts every search report in a KMP model of its own
// and checks each result in order. Depends on kmp_pkg and the core RTL.
`timescale 1ns / 100ps

module kmp_substring_search_core_tb;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int RUN_ITEMS = 820;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_FROM = 300;
  localparam int CALM_TO = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  kmp_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kmp_pkg::out_t out_item;

  // Pattern, failure table and match state of the predictor.
  logic [7:0] pat_mem [kmp_pkg::MAX_PATTERN];
  logic [kmp_pkg::LEN_W-1:0] fail_mem [kmp_pkg::MAX_PATTERN];
  logic [kmp_pkg::LEN_W-1:0] pat_len = '0;
  logic [kmp_pkg::LEN_W-1:0] match_len = '0;
  logic seen_any = 1'b0;

  kmp_pkg::in_t command_q [$];
  kmp_pkg::out_t report_q [$];
  int sent_count = 0;
  int seen_count = 0;
  int err_count = 0;
  int cycle_count = 0;

  kmp_substring_search_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Walks the failure links from pos until byte c extends the matched prefix.
  function automatic logic [kmp_pkg::LEN_W-1:0] kmp_advance(
    logic [kmp_pkg::LEN_W-1:0] pos,
    logic [7:0] c
  );
    while (pos > 0 && c != pat_mem[pos]) begin
      pos = fail_mem[pos - 1];
    end
    if (c == pat_mem[pos]) begin
      pos = pos + 1'b1;
    end
    return pos;
  endfunction

  function automatic kmp_pkg::out_t search_step(kmp_pkg::in_t it);
    kmp_pkg::out_t r;
    logic [kmp_pkg::LEN_W-1:0] j;
    r = '0;
    case (it.mode)
      kmp_pkg::MODE_PATTERN: begin
        if (pat_len >= kmp_pkg::MAX_PATTERN) begin
          r.overflow = 1'b1;
        end else begin
          pat_mem[pat_len] = it.symbol;
          if (pat_len == 0) begin
            fail_mem[0] = '0;
          end else begin
            fail_mem[pat_len] = kmp_advance(fail_mem[pat_len - 1], it.symbol);
          end
          pat_len = pat_len + 1'b1;
          match_len = '0;
          seen_any = 1'b0;
        end
      end
      kmp_pkg::MODE_TEXT: begin
        if (pat_len == 0) begin
          r.match_end = 1'b1;
        end else begin
          j = kmp_advance(match_len, it.symbol);
          // A full match falls back so that overlapping occurrences count.
          if (j >= pat_len) begin
            r.match_end = 1'b1;
            j = fail_mem[pat_len - 1];
          end
          match_len = j;
        end
        if (r.match_end) begin
          seen_any = 1'b1;
        end
        r.found = seen_any;
        if (it.text_last) begin
          r.done_res = 1'b1;
          match_len = '0;
          seen_any = 1'b0;
        end
      end
      kmp_pkg::MODE_CLEAR: begin
        pat_len = '0;
        match_len = '0;
        seen_any = 1'b0;
      end
      default: begin
      end
    endcase
    r.pattern_length = pat_len;
    return r;
  endfunction

  task automatic add_cmd(logic [1:0] mode, logic [7:0] symbol, logic last);
    kmp_pkg::in_t it;
    it.mode = mode;
    it.symbol = symbol;
    it.text_last = last;
    command_q = {command_q, it};
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Driver: a new transaction is presented once the current one is taken.
  always @(posedge clk) begin
    logic hold;
    if (!rst) begin
      hold = !(sent_count >= CALM_FROM && sent_count < CALM_TO) &&
             ($urandom_range(99) < 14);
      if (in_valid && in_ready) begin
        report_q = {report_q, search_step(in_item)};
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (command_q.size() > 0 && !hold) begin
          in_valid <= 1'b1;
          in_item <= command_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result is compared with the oldest predicted report.
  always @(posedge clk) begin
    kmp_pkg::out_t want;
    logic hold;
    if (!rst) begin
      hold = !(seen_count >= CALM_FROM && seen_count < CALM_TO) &&
             ($urandom_range(99) < 14);
      if (out_valid && out_ready) begin
        seen_count <= seen_count + 1;
        if (report_q.size() == 0) begin
          note_error($sformatf("unexpected result %p", out_item));
        end else begin
          want = report_q.pop_front();
          if (out_item.match_end !== want.match_end ||
              out_item.found !== want.found ||
              out_item.done_res !== want.done_res ||
              out_item.pattern_length !== want.pattern_length ||
              out_item.overflow !== want.overflow) begin
            note_error($sformatf("result %0d: expected %p, got %p",
                                 seen_count, want, out_item));
          end
        end
      end
      out_ready <= !hold;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    logic wide;
    int plen;
    int ntext;
    int tlen;
    int kind;

    // Empty pattern: every text byte matches.
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b1);
    add_cmd(MODE_NOP, 8'hA5, 1'b1);
    // Pattern with overlapping occurrences in the text.
    add_cmd(kmp_pkg::MODE_PATTERN, 8'h00, 1'b1);
    add_cmd(kmp_pkg::MODE_PATTERN, 8'hFF, 1'b0);
    add_cmd(kmp_pkg::MODE_PATTERN, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h7F, 1'b1);
    // A pattern byte arriving while a text is open resets the match state.
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b0);
    add_cmd(kmp_pkg::MODE_PATTERN, 8'hFF, 1'b1);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
    add_cmd(kmp_pkg::MODE_TEXT, 8'hFF, 1'b1);
    add_cmd(MODE_NOP, 8'h5A, 1'b0);
    add_cmd(kmp_pkg::MODE_CLEAR, 8'hFF, 1'b1);
    add_cmd(kmp_pkg::MODE_TEXT, 8'h80, 1'b1);

    while (command_q.size() < RUN_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        sym_a = 8'($urandom);
        sym_b = ($urandom_range(3) == 0) ? (sym_a ^ 8'h01) : 8'($urandom);
        wide = ($urandom_range(15) == 0);
        add_cmd(kmp_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom_range(1)));
        // Long patterns run up to and past capacity to hit the overflow case.
        plen = wide ? $urandom_range(60, 68) : $urandom_range(1, 6);
        for (int i = 0; i < plen; i++) begin
          if (wide) begin
            add_cmd(kmp_pkg::MODE_PATTERN, ($urandom_range(15) == 0) ? sym_b : sym_a,
                    1'($urandom_range(1)));
          end else begin
            add_cmd(kmp_pkg::MODE_PATTERN, $urandom_range(1) ? sym_b : sym_a,
                    1'($urandom_range(1)));
          end
        end
        ntext = wide ? 1 : $urandom_range(1, 3);
        for (int t = 0; t < ntext; t++) begin
          tlen = wide ? $urandom_range(60, 72) : $urandom_range(1, 16);
          for (int i = 0; i < tlen; i++) begin
            if (wide) begin
              sym_b = ($urandom_range(19) == 0) ? sym_b : sym_a;
              add_cmd(kmp_pkg::MODE_TEXT, sym_b, i == tlen - 1);
              sym_b = sym_a ^ 8'h01;
            end else begin
              // Now and then a text runs on without its closing byte.
              add_cmd(kmp_pkg::MODE_TEXT, $urandom_range(1) ? sym_b : sym_a,
                      (i == tlen - 1) && ($urandom_range(7) != 0));
            end
          end
        end
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          add_cmd(($urandom_range(24) == 0) ? MODE_NOP : 2'($urandom_range(2)),
                  8'($urandom), 1'($urandom_range(1)));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (command_q.size() > 0 || in_valid || report_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (err_count == 0 && report_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/kmp_pkg.sv
sv/kmp_cell.sv
sv/kmp_substring_search_core.sv
tb/kmp_substring_search_core_tb.sv
